>>> src/rpmt_pkg.sv
// shared types and constants for the refcounted page map table
// depends on nothing; imported by rpmt_store and refcounted_page_map_table
package rpmt_pkg;

	// table geometry
	localparam int ENTRIES    = 128;
	localparam int REF_BITS   = 32;
	localparam int ADDR_BITS  = 64;
	localparam int SLOT_BITS  = $clog2(ENTRIES);
	localparam int COUNT_BITS = $clog2(ENTRIES + 1);

	// reset value of the user limit register
	localparam logic [ADDR_BITS-1:0] USER_LIMIT_RESET = ADDR_BITS'(64'h0000_8000_0000_0000);

	// largest reference count, counts saturate here
	localparam logic [REF_BITS-1:0] REF_MAX = '1;

	// request kinds
	typedef enum logic [0:0] {
		OP_MAP   = 1'b0,
		OP_UNMAP = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	// actions reported to the host
	typedef enum logic [2:0] {
		ACT_NONE         = 3'd0,
		ACT_MAP_USER     = 3'd1,
		ACT_MAP_KERNEL   = 3'd2,
		ACT_UNMAP_USER   = 3'd3,
		ACT_UNMAP_KERNEL = 3'd4
	} action_t;

	// request sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	// one table entry as held in memory
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [REF_BITS-1:0]  refs;
	} entry_t;

	// write request into the entry store
	typedef struct packed {
		logic                 en;
		logic [SLOT_BITS-1:0] idx;
		logic                 valid;
		entry_t               entry;
	} store_wr_t;

	// registered read response from the entry store
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} store_rd_t;

endpackage

>>> src/rpmt_store.sv
// entry store: synchronous memory of addresses and counts with one read port and one write port, plus valid flags
// depends on rpmt_pkg
module rpmt_store import rpmt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [SLOT_BITS-1:0] rd_idx,
	output store_rd_t            rd,
	input  store_wr_t            wr
);

	entry_t             mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t             rd_entry_q;
	logic               rd_valid_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx];
		end
	end

	// valid flags, cleared by reset so stale entries never match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= wr.valid;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	assign rd.valid = rd_valid_q;
	assign rd.entry = rd_entry_q;

endmodule

>>> src/refcounted_page_map_table.sv
// top level of the refcounted page map table: request sequencer, compare stage and result register
// depends on rpmt_pkg and rpmt_store

// Once a request beat is accepted, the scan state reads every slot in turn through the single
// read port of the entry memory, the drain state makes the last compare and the commit state
// writes back and loads the result register. The sequencer then returns to idle to take the
// next request, so a new request is not taken before the last one has committed.
// That next request is accepted even while the previous result waits on m_tready; its commit
// stalls only if the previous result has still not been taken. The memory needs no clearing
// pass after reset since every slot carries a valid flag cleared by reset.
module refcounted_page_map_table import rpmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] page_address
	input  logic [0:0]  s_tuser,   // [0] operation
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [1:0] status, [4:2] os_action, [36:5] ref_count,
	                               // [43:37] slot, [51:44] live_entries, [55:52] zero
	// user limit register
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	state_t state_q, state_next;

	logic [ADDR_BITS-1:0]  user_limit_q;
	op_t                   op_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [SLOT_BITS-1:0]  scan_idx_q;
	logic [COUNT_BITS-1:0] live_q;

	logic                  cmp_s1;
	logic [SLOT_BITS-1:0]  slot_s1;

	logic                  match_found_q;
	logic [SLOT_BITS-1:0]  match_slot_q;
	logic [REF_BITS-1:0]   match_refs_q;
	logic                  free_found_q;
	logic [SLOT_BITS-1:0]  free_slot_q;

	logic                  accept;
	logic                  rd_en;
	logic                  commit_go;
	logic                  scan_last;
	store_rd_t             rd;
	store_wr_t             wr;

	status_t               res_status;
	action_t               res_action;
	logic [REF_BITS-1:0]   res_refs;
	logic [SLOT_BITS-1:0]  res_slot;
	logic [COUNT_BITS-1:0] live_next;
	logic                  user_page;

	logic                  m_tvalid_q;
	logic [55:0]           m_tdata_q;

	assign accept    = s_tvalid && s_tready;
	assign scan_last = (scan_idx_q == SLOT_BITS'(ENTRIES - 1));

	// entry memory
	rpmt_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_idx (scan_idx_q),
		.rd     (rd),
		.wr     (wr)
	);

	// sequencer next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_next = ST_SCAN;
			ST_SCAN:   if (scan_last) state_next = ST_DRAIN;
			ST_DRAIN:  state_next = ST_COMMIT;
			ST_COMMIT: if (commit_go) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		commit_go = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   rd_en = 1'b1;
			ST_DRAIN:  ;
			ST_COMMIT: commit_go = !m_tvalid_q || m_tready;
			default:   ;
		endcase
	end

	// state, scan counter and user limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			user_limit_q <= USER_LIMIT_RESET;
			cmp_s1       <= 1'b0;
		end else begin
			state_q <= state_next;
			cmp_s1  <= rd_en;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cfg_we) begin
				user_limit_q <= cfg_wdata;
			end
		end
	end

	// request capture and read slot pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(s_tuser[0]);
			addr_q <= s_tdata;
		end
		slot_s1 <= scan_idx_q;
	end

	// compare stage: first matching valid slot and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (accept) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmp_s1) begin
			if (rd.valid && rd.entry.addr == addr_q && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!rd.valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_s1) begin
			if (rd.valid && rd.entry.addr == addr_q && !match_found_q) begin
				match_slot_q <= slot_s1;
				match_refs_q <= rd.entry.refs;
			end
			if (!rd.valid && !free_found_q) begin
				free_slot_q <= slot_s1;
			end
		end
	end

	assign user_page = addr_q < user_limit_q;

	// commit decision and write-back
	always_comb begin
		res_status      = STATUS_OK;
		res_action      = ACT_NONE;
		res_refs        = '0;
		res_slot        = '0;
		live_next       = live_q;
		wr.en           = 1'b0;
		wr.idx          = match_slot_q;
		wr.valid        = 1'b1;
		wr.entry.addr   = addr_q;
		wr.entry.refs   = match_refs_q;
		case (op_q)
			OP_MAP: begin
				if (match_found_q) begin
					res_refs = (match_refs_q == REF_MAX) ? match_refs_q : match_refs_q + 1'b1;
					res_slot = match_slot_q;
					wr.en    = commit_go;
					wr.entry.refs = res_refs;
				end else if (free_found_q) begin
					res_action    = user_page ? ACT_MAP_USER : ACT_MAP_KERNEL;
					res_refs      = REF_BITS'(1);
					res_slot      = free_slot_q;
					live_next     = live_q + 1'b1;
					wr.en         = commit_go;
					wr.idx        = free_slot_q;
					wr.entry.refs = REF_BITS'(1);
				end else begin
					res_status = STATUS_FULL;
				end
			end
			OP_UNMAP: begin
				if (!match_found_q) begin
					res_status = STATUS_NOT_FOUND;
				end else if (match_refs_q <= REF_BITS'(1)) begin
					res_action    = user_page ? ACT_UNMAP_USER : ACT_UNMAP_KERNEL;
					res_slot      = match_slot_q;
					live_next     = (live_q != '0) ? live_q - 1'b1 : live_q;
					wr.en         = commit_go;
					wr.valid      = 1'b0;
					wr.entry.refs = '0;
				end else begin
					res_refs      = match_refs_q - 1'b1;
					res_slot      = match_slot_q;
					wr.en         = commit_go;
					wr.entry.refs = res_refs;
				end
			end
			default: ;
		endcase
	end

	// live count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (commit_go) begin
				live_q     <= live_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			m_tdata_q <= {4'b0, 8'(live_next), 7'(res_slot), 32'(res_refs),
				res_action, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// occupancy never exceeds the table
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= COUNT_BITS'(ENTRIES))
		else $error("live count above table size");

	// an accepted request always starts its scan at slot zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN && scan_idx_q == '0))
		else $error("scan did not start at slot zero");

	// a full report only when every slot is occupied
	a_full_live: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_go && res_status == STATUS_FULL) |-> (live_q == COUNT_BITS'(ENTRIES)))
		else $error("table full reported with free slots");

	// not found only for unmap requests
	a_not_found_op: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_go && res_status == STATUS_NOT_FOUND) |-> (op_q == OP_UNMAP))
		else $error("not found reported for a map request");
`endif

endmodule
